FILE: hdl/radix_to_ascii_converter_core_assert.svh
// Assertion macros for the converter core RTL.
`ifndef RADIX_TO_ASCII_CONVERTER_CORE_ASSERT_SVH
`define RADIX_TO_ASCII_CONVERTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define R2A_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("r2a assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define R2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("r2a assertion failed");

`else

`define R2A_ASSERT_SAME(label, clk, rst, ante, cons)
`define R2A_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/r2a_pkg.sv
`timescale 1ns / 1ps

package r2a_pkg;

   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 7;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_NONE = 7'h00;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO = 7'h30;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_X    = 7'h78;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_A    = 7'h41;

   localparam logic [RADIX_WIDTH-1:0] HEX_RADIX     = 6'd16;
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_SPLIT = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DIV_START = 8'b0000_0010,
      ST_DIV_WAIT  = 8'b0000_0100,
      ST_PFX_ZERO  = 8'b0000_1000,
      ST_PFX_X     = 8'b0001_0000,
      ST_POP       = 8'b0010_0000,
      ST_DIGIT     = 8'b0100_0000,
      ST_ERROR     = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [DIGIT_WIDTH-1:0] upper;
      upper = d - DECIMAL_SPLIT;
      if (d < DECIMAL_SPLIT) begin
         return CHAR_ZERO + {1'b0, d};
      end else begin
         return CHAR_A + {1'b0, upper};
      end
   endfunction

endpackage

FILE: hdl/radix_to_ascii_converter_core.sv
`timescale 1ns / 1ps

// Converts an unsigned value to ASCII in a radix from 2 to 36. One transaction on the req_
// channel yields a string of characters on the rsp_ channel: '0', then 'x' for radix 16, then
// the digits most significant first, with rsp_last on the final one. A radix outside 2 to 36
// yields a single character 0 with rsp_error and rsp_last set. A single bit-serial divider
// produces every digit; the digits are stacked and then popped for output. A new request is
// not taken while a string is in progress: req_ready is high only in the idle state, which
// the state machine reenters after the last character has been loaded for output.
module radix_to_ascii_converter_core
   import r2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_WIDTH-1:0] req_radix,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_character,
   output logic                   rsp_last,
   output logic                   rsp_error
);

   `include "radix_to_ascii_converter_core_assert.svh"

   localparam int IDX_WIDTH = $clog2(STACK_DEPTH);
   localparam int CNT_WIDTH = $clog2(STACK_DEPTH + 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_error_ff, rsp_error_in;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [DIGIT_WIDTH-1:0] div_rem;

   stack_ctl_type          stack_ctl;
   logic [IDX_WIDTH-1:0]   stack_addr;
   logic [DIGIT_WIDTH-1:0] stack_rd;
   logic [CNT_WIDTH-1:0]   count_dec;

   logic                   out_free;
   logic                   radix_bad;
   logic                   is_hex;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign radix_bad = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign is_hex    = (radix_ff == HEX_RADIX);
   assign count_dec = count_ff - 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      radix_in     = radix_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      div_start    = 1'b0;
      stack_ctl    = '0;
      stack_addr   = count_ff[IDX_WIDTH-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               quot_in  = req_value;
               radix_in = req_radix;
               count_in = '0;
               state_in = radix_bad ? ST_ERROR : ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               quot_in = div_quot;
               if (count_ff < CNT_WIDTH'(STACK_DEPTH)) begin
                  stack_ctl.push = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
               state_in = (div_quot == '0) ? ST_PFX_ZERO : ST_DIV_START;
            end
         end
         ST_PFX_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO;
               rsp_last_in  = ~is_hex && (count_ff == '0);
               rsp_error_in = 1'b0;
               state_in     = is_hex ? ST_PFX_X : ST_POP;
            end
         end
         ST_PFX_X: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_X;
               rsp_last_in  = (count_ff == '0);
               rsp_error_in = 1'b0;
               state_in     = ST_POP;
            end
         end
         ST_POP: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               stack_ctl.pop = 1'b1;
               stack_addr    = count_dec[IDX_WIDTH-1:0];
               count_in      = count_dec;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(stack_rd);
               rsp_last_in  = (count_ff == '0);
               rsp_error_in = 1'b0;
               state_in     = ST_POP;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_NONE;
               rsp_last_in  = 1'b1;
               rsp_error_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quot_ff      <= '0;
         radix_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quot_ff      <= quot_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   r2a_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (quot_ff),
      .divisor  (radix_ff),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   r2a_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .ctl    (stack_ctl),
      .addr   (stack_addr),
      .wr_data(div_rem),
      .rd_data(stack_rd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_error     = rsp_error_ff;

   `R2A_ASSERT_SAME(a_error_is_last, clock, reset, rsp_valid && rsp_error, rsp_last)
   `R2A_ASSERT_SAME(a_error_char, clock, reset, rsp_valid && rsp_error, rsp_character == CHAR_NONE)
   `R2A_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_WIDTH'(STACK_DEPTH))
   `R2A_ASSERT_SAME(a_done_in_wait, clock, reset, div_done, state_ff == ST_DIV_WAIT)
   `R2A_ASSERT_SAME(a_rem_below_radix, clock, reset, div_done, div_rem < radix_ff)
   `R2A_ASSERT_NEXT(a_start_leads_wait, clock, reset, div_start, state_ff == ST_DIV_WAIT)

endmodule

FILE: hdl/r2a_divider.sv
`timescale 1ns / 1ps

// Restoring divider that produces one quotient bit per cycle.
module r2a_divider
   import r2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [DIGIT_WIDTH-1:0] remainder
);

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic [VALUE_WIDTH-1:0] quo_ff;
   logic [DIGIT_WIDTH-1:0] rem_ff;

   logic [DIGIT_WIDTH:0]   shifted;
   logic [DIGIT_WIDTH+1:0] trial;
   logic                   fits;

   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};
   assign fits    = ~trial[DIGIT_WIDTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff & ~start & (cnt_ff == CNT_WIDTH'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_WIDTH'(VALUE_WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_ff <= fits ? trial[DIGIT_WIDTH-1:0] : shifted[DIGIT_WIDTH-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/r2a_stack.sv
`timescale 1ns / 1ps

// Digit stack with one address port and registered read data.
module r2a_stack
   import r2a_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic                           clock,
   input  stack_ctl_type                  ctl,
   input  logic [$clog2(STACK_DEPTH)-1:0] addr,
   input  logic [DIGIT_WIDTH-1:0]         wr_data,
   output logic [DIGIT_WIDTH-1:0]         rd_data
);

   logic [DIGIT_WIDTH-1:0] mem [STACK_DEPTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[addr] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
